### design/pior_pkg.sv
// Shared constants and types for the point-in-oriented-rectangle test.
// Depends on nothing; used by point_in_oriented_rect.

package pior_pkg;

  localparam int CoordW = 32;
  localparam int FracW  = 16;

  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int SumW   = ProdW + 1;
  localparam int MagW   = ProdW;
  localparam int ScaleW = MagW + 10;
  localparam int LimbW  = (ScaleW + 2) / 3;
  localparam int PadW   = 3 * LimbW;
  localparam int SqW    = 2 * PadW;

  localparam int CfgIdxW = 3;

  // largest squared edge length that still counts as too small
  localparam longint unsigned SmallLim =
    ((64'd1 << (2 * FracW)) - 64'd1) / 64'd1000000;

  localparam int SettleCycles = 9;
  localparam int SettleW      = 4;

  typedef enum logic [CfgIdxW-1:0] {
    RegAx = 3'd0,
    RegAy = 3'd1,
    RegBx = 3'd2,
    RegBy = 3'd3,
    RegCx = 3'd4,
    RegCy = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StatValid = 2'd0,
    StatSmall = 2'd1,
    StatSkew  = 2'd2
  } status_e;

endpackage

### design/point_in_oriented_rect.sv
// Point-in-oriented-rectangle test, four-stage item pipeline plus a
// free-running corner pipeline. Depends on pior_pkg.
//
// channel  direction  handshake                    payload
// in       input      in_valid_i / in_ready_o      point_x_i, point_y_i
// out      output     out_valid_o / out_ready_i    inside_res_o, status_o
// cfg      input      cfg_we_i (no wait)           cfg_idx_i, cfg_data_i
//
// One item per cycle while out is not stalled and the corner path has settled.
// The corner path (squared edge length, squared projection) is nine register
// stages deep; after reset and after every config write, in_ready_o stays low
// while it settles.
// A stall on out holds the occupied stages up to the first empty one; earlier items still move into empty stages.

module point_in_oriented_rect (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pior_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pior_pkg::CoordW-1:0]        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [pior_pkg::CoordW-1:0] point_x_i,
  input  logic signed [pior_pkg::CoordW-1:0] point_y_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               inside_res_o,
  output logic [1:0]                         status_o
);

  localparam int CoordW = pior_pkg::CoordW;
  localparam int DiffW  = pior_pkg::DiffW;
  localparam int ProdW  = pior_pkg::ProdW;
  localparam int SumW   = pior_pkg::SumW;
  localparam int MagW   = pior_pkg::MagW;
  localparam int ScaleW = pior_pkg::ScaleW;
  localparam int LimbW  = pior_pkg::LimbW;
  localparam int PadW   = pior_pkg::PadW;
  localparam int SqW    = pior_pkg::SqW;
  localparam int FracW  = pior_pkg::FracW;

  // corner registers
  logic signed [CoordW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic [pior_pkg::SettleW-1:0] settle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q <= '0;
      ay_q <= '0;
      bx_q <= '0;
      by_q <= '0;
      cx_q <= '0;
      cy_q <= '0;
    end else if (cfg_we_i) begin
      unique case (pior_pkg::cfg_idx_e'(cfg_idx_i))
        pior_pkg::RegAx: ax_q <= cfg_data_i;
        pior_pkg::RegAy: ay_q <= cfg_data_i;
        pior_pkg::RegBx: bx_q <= cfg_data_i;
        pior_pkg::RegBy: by_q <= cfg_data_i;
        pior_pkg::RegCx: cx_q <= cfg_data_i;
        pior_pkg::RegCy: cy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= pior_pkg::SettleW'(pior_pkg::SettleCycles);
    end else if (cfg_we_i) begin
      settle_q <= pior_pkg::SettleW'(pior_pkg::SettleCycles);
    end else if (settle_q != '0) begin
      settle_q <= settle_q - 1'b1;
    end
  end

  // corner pipeline, free running
  logic signed [DiffW-1:0] dx_q, dy_q, ex_q, ey_q;
  logic signed [ProdW-1:0] dxdx_q, dydy_q, exdx_q, eydy_q, eydx_q, exdy_q;
  logic signed [SumW-1:0]  len2_q, dotc_q, crossc_q;
  logic signed [SumW-1:0]  lo_q, hi_q;
  logic                    small_q;
  logic [ScaleW-1:0]       scale_q;
  logic [MagW-1:0]         mag;
  logic [ScaleW-1:0]       mag_w;
  logic [PadW-1:0]         pad;
  logic [LimbW-1:0]        l0, l1, l2;
  logic [2*LimbW-1:0]      p00_q, p01_q, p02_q, p11_q, p12_q, p22_q;
  logic [SqW-1:0]          lo6_q, mid6_q, hi6_q, lo7_q, up7_q, sq_q;
  pior_pkg::status_e       cstat_q;

  always_comb begin
    mag   = MagW'(dotc_q[SumW-1] ? -dotc_q : dotc_q);
    mag_w = ScaleW'(mag);
    pad   = PadW'(scale_q);
    l0    = pad[LimbW-1:0];
    l1    = pad[2*LimbW-1:LimbW];
    l2    = pad[3*LimbW-1:2*LimbW];
  end

  always_ff @(posedge clk_i) begin
    dx_q     <= DiffW'(bx_q) - DiffW'(ax_q);
    dy_q     <= DiffW'(by_q) - DiffW'(ay_q);
    ex_q     <= DiffW'(cx_q) - DiffW'(ax_q);
    ey_q     <= DiffW'(cy_q) - DiffW'(ay_q);

    dxdx_q   <= ProdW'(dx_q) * ProdW'(dx_q);
    dydy_q   <= ProdW'(dy_q) * ProdW'(dy_q);
    exdx_q   <= ProdW'(ex_q) * ProdW'(dx_q);
    eydy_q   <= ProdW'(ey_q) * ProdW'(dy_q);
    eydx_q   <= ProdW'(ey_q) * ProdW'(dx_q);
    exdy_q   <= ProdW'(ex_q) * ProdW'(dy_q);

    len2_q   <= SumW'(dxdx_q) + SumW'(dydy_q);
    dotc_q   <= SumW'(exdx_q) + SumW'(eydy_q);
    crossc_q <= SumW'(eydx_q) - SumW'(exdy_q);

    small_q  <= $unsigned(len2_q) <= SumW'(pior_pkg::SmallLim);
    scale_q  <= (mag_w << 10) - (mag_w << 4) - (mag_w << 3);
    lo_q     <= crossc_q[SumW-1] ? crossc_q : '0;
    hi_q     <= crossc_q[SumW-1] ? '0 : crossc_q;

    p00_q    <= (2*LimbW)'(l0) * (2*LimbW)'(l0);
    p01_q    <= (2*LimbW)'(l0) * (2*LimbW)'(l1);
    p02_q    <= (2*LimbW)'(l0) * (2*LimbW)'(l2);
    p11_q    <= (2*LimbW)'(l1) * (2*LimbW)'(l1);
    p12_q    <= (2*LimbW)'(l1) * (2*LimbW)'(l2);
    p22_q    <= (2*LimbW)'(l2) * (2*LimbW)'(l2);

    lo6_q    <= SqW'(p00_q) + (SqW'(p01_q) << (LimbW + 1));
    mid6_q   <= (SqW'(p02_q) << 1) + SqW'(p11_q);
    hi6_q    <= (SqW'(p12_q) << (LimbW + 1)) + (SqW'(p22_q) << (2 * LimbW));

    lo7_q    <= lo6_q;
    up7_q    <= mid6_q + hi6_q;

    sq_q     <= lo7_q + (up7_q << (2 * LimbW));

    if (small_q) begin
      cstat_q <= pior_pkg::StatSmall;
    end else if (sq_q > (SqW'($unsigned(len2_q)) << (2 * FracW))) begin
      cstat_q <= pior_pkg::StatSkew;
    end else begin
      cstat_q <= pior_pkg::StatValid;
    end
  end

  // item pipeline
  logic v1_q, v2_q, v3_q, vo_q;
  logic adv1, adv2, adv3, advo;
  logic accept;
  logic signed [DiffW-1:0] px1_q, py1_q;
  logic signed [ProdW-1:0] pxdx_q, pydy_q, pydx_q, pxdy_q;
  logic signed [SumW-1:0]  dotp_q, crossp_q;
  logic                    inside_q;
  pior_pkg::status_e       status_q;
  logic                    inside_d;

  assign advo       = !vo_q || out_ready_i;
  assign adv3       = !v3_q || advo;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1 && (settle_q == '0);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    inside_d = (cstat_q == pior_pkg::StatValid) &&
               !dotp_q[SumW-1] && (dotp_q <= len2_q) &&
               (crossp_q >= lo_q) && (crossp_q <= hi_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= accept;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (advo) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      px1_q <= DiffW'(point_x_i) - DiffW'(ax_q);
      py1_q <= DiffW'(point_y_i) - DiffW'(ay_q);
    end
    if (adv2) begin
      pxdx_q <= ProdW'(px1_q) * ProdW'(dx_q);
      pydy_q <= ProdW'(py1_q) * ProdW'(dy_q);
      pydx_q <= ProdW'(py1_q) * ProdW'(dx_q);
      pxdy_q <= ProdW'(px1_q) * ProdW'(dy_q);
    end
    if (adv3) begin
      dotp_q   <= SumW'(pxdx_q) + SumW'(pydy_q);
      crossp_q <= SumW'(pydx_q) - SumW'(pxdy_q);
    end
    if (advo) begin
      inside_q <= inside_d;
      status_q <= cstat_q;
    end
  end

  assign out_valid_o  = vo_q;
  assign inside_res_o = inside_q;
  assign status_o     = status_q;

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v1_q)
    else $error("accepted item missing from first stage");

  a_cfg_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_o)
    else $error("input taken while corner path settles");

  a_bad_rect : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != pior_pkg::StatValid) |-> !inside_res_o)
    else $error("inside flag set for invalid rectangle");

  a_mid_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !adv3 |=> v3_q)
    else $error("stalled item dropped from third stage");

endmodule
